// File: src/assert_macros.svh
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset
`define XPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset
`define XPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/xpf_pkg.sv
// Shared types and constants of the XOR parity FEC encoder
package xpf_pkg;

    localparam int SEQ_W   = 32;
    localparam int WORD_W  = 64;
    localparam int POS_W   = 5;
    localparam int GS_W    = 8;
    localparam int KIND_W  = 2;
    localparam int QDEPTH  = 2;
    localparam logic [GS_W-1:0] GROUP_SIZE_RST = 8'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_EVEN = 2'd2
    } frame_kind_t;

    typedef enum logic [1:0] {
        BK_DATA = 2'd0,
        BK_ROW  = 2'd1,
        BK_EVEN = 2'd2
    } back_state_t;

    // One classified word, handed from the front end to the back end
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  base;
        logic [SEQ_W-1:0]  first_seq;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              even;
        logic              close;
    } fec_entry_t;

endpackage

// File: src/xpf_in_if.sv
// Input and output stream interfaces
interface xpf_in_if;
    logic                      valid;
    logic                      ready;
    logic [xpf_pkg::SEQ_W-1:0]  frame_seq;
    logic [xpf_pkg::WORD_W-1:0] payload_word;

    modport source (output valid, output frame_seq, output payload_word, input ready);
    modport sink   (input valid, input frame_seq, input payload_word, output ready);
endinterface

interface xpf_out_if;
    logic                       valid;
    logic                       ready;
    logic [xpf_pkg::KIND_W-1:0] frame_kind;
    logic [xpf_pkg::SEQ_W-1:0]  out_seq;
    logic [xpf_pkg::SEQ_W-1:0]  base_seq;
    logic [xpf_pkg::POS_W-1:0]  word_position;
    logic [xpf_pkg::WORD_W-1:0] out_word;
    logic                       run_last;

    modport source (output valid, output frame_kind, output out_seq, output base_seq,
                    output word_position, output out_word, output run_last, input ready);
    modport sink   (input valid, input frame_kind, input out_seq, input base_seq,
                    input word_position, input out_word, input run_last, output ready);
endinterface

// File: src/xpf_front.sv
// Front end: accepts words, tracks frame and group position, classifies each word
`include "assert_macros.svh"

module xpf_front #(
    parameter int WORDS_PER_FRAME = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    xpf_in_if.sink                    in_stream,
    input  logic                      cfg_wr_en,
    input  logic [xpf_pkg::GS_W-1:0]  cfg_wr_data,
    input  logic                      q_ready,
    output logic                      q_push,
    output xpf_pkg::fec_entry_t       q_entry
);

    localparam logic [xpf_pkg::POS_W-1:0] LAST_POS = xpf_pkg::POS_W'(WORDS_PER_FRAME - 1);

    logic [xpf_pkg::GS_W-1:0]  group_size_reg;
    logic [xpf_pkg::POS_W-1:0] wc_reg, wc_next;
    logic [xpf_pkg::GS_W-1:0]  frames_reg, frames_next;
    logic [xpf_pkg::SEQ_W-1:0] cur_seq_reg, cur_seq_next;
    logic [xpf_pkg::SEQ_W-1:0] first_seq_reg, first_seq_next;

    logic                      first_word;
    logic                      frame_end;
    logic                      close;
    logic [xpf_pkg::GS_W-1:0]  frames_inc;
    logic [xpf_pkg::SEQ_W-1:0] seq_now;
    logic [xpf_pkg::SEQ_W-1:0] first_now;

    assign in_stream.ready = q_ready;
    assign q_push          = in_stream.valid && q_ready;

    always_comb
    begin
        first_word = (wc_reg == '0);
        frame_end  = (wc_reg == LAST_POS);
        frames_inc = frames_reg + xpf_pkg::GS_W'(1);
        // Zero group size closes every frame, as does a size lowered below the count
        close      = frame_end && (frames_inc >= group_size_reg);
        seq_now    = first_word ? in_stream.frame_seq : cur_seq_reg;
        first_now  = (first_word && frames_reg == '0) ? seq_now : first_seq_reg;

        q_entry.seq       = seq_now;
        q_entry.base      = seq_now - xpf_pkg::SEQ_W'(frames_reg);
        q_entry.first_seq = first_now;
        q_entry.pos       = wc_reg;
        q_entry.word      = in_stream.payload_word;
        q_entry.even      = ~frames_reg[0];
        q_entry.close     = close;

        wc_next        = wc_reg;
        frames_next    = frames_reg;
        cur_seq_next   = cur_seq_reg;
        first_seq_next = first_seq_reg;
        if (q_push)
        begin
            cur_seq_next   = seq_now;
            first_seq_next = first_now;
            if (frame_end)
            begin
                wc_next     = '0;
                frames_next = close ? '0 : frames_inc;
            end
            else
            begin
                wc_next = wc_reg + xpf_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= xpf_pkg::GROUP_SIZE_RST;
            wc_reg         <= '0;
            frames_reg     <= '0;
            cur_seq_reg    <= '0;
            first_seq_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                group_size_reg <= cfg_wr_data;
            end
            wc_reg        <= wc_next;
            frames_reg    <= frames_next;
            cur_seq_reg   <= cur_seq_next;
            first_seq_reg <= first_seq_next;
        end
    end

    `XPF_ASSERT_NEXT(a_group_restart, q_push && close, frames_reg == '0 && wc_reg == '0,
        "front: closing word did not restart the group")

endmodule

// File: src/xpf_queue.sv
// Two-entry queue between the front end and the back end
module xpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xpf_pkg::fec_entry_t push_data,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output xpf_pkg::fec_entry_t pop_data
);

    localparam int PTR_W = $clog2(xpf_pkg::QDEPTH);
    localparam int CNT_W = $clog2(xpf_pkg::QDEPTH + 1);

    xpf_pkg::fec_entry_t  mem_reg [xpf_pkg::QDEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign not_full  = (count_reg != CNT_W'(xpf_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/xpf_back.sv
// Back end: passes data words, accumulates parity, dumps parity frames at group close
`include "assert_macros.svh"

module xpf_back #(
    parameter int WORDS_PER_FRAME = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  xpf_pkg::fec_entry_t q_data,
    output logic                q_pop,
    xpf_out_if.source           out_stream
);

    localparam int IDX_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS_PER_FRAME - 1);

    logic [xpf_pkg::WORD_W-1:0] all_parity_reg  [WORDS_PER_FRAME];
    logic [xpf_pkg::WORD_W-1:0] even_parity_reg [WORDS_PER_FRAME];

    xpf_pkg::back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [xpf_pkg::SEQ_W-1:0]  fs_reg, fs_next;

    logic                       out_valid_reg;
    xpf_pkg::frame_kind_t       out_kind_reg;
    logic [xpf_pkg::SEQ_W-1:0]  out_seq_reg;
    logic [xpf_pkg::SEQ_W-1:0]  out_base_reg;
    logic [xpf_pkg::POS_W-1:0]  out_pos_reg;
    logic [xpf_pkg::WORD_W-1:0] out_word_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       load;
    xpf_pkg::frame_kind_t       ld_kind;
    logic [xpf_pkg::SEQ_W-1:0]  ld_seq;
    logic [xpf_pkg::SEQ_W-1:0]  ld_base;
    logic [xpf_pkg::POS_W-1:0]  ld_pos;
    logic [xpf_pkg::WORD_W-1:0] ld_word;
    logic                       ld_last;

    logic [IDX_W-1:0]           addr;
    logic                       all_we;
    logic                       even_we;
    logic [xpf_pkg::WORD_W-1:0] all_wdata;
    logic [xpf_pkg::WORD_W-1:0] even_wdata;

    assign out_free = !out_valid_reg || out_stream.ready;

    assign out_stream.valid         = out_valid_reg;
    assign out_stream.frame_kind    = out_kind_reg;
    assign out_stream.out_seq       = out_seq_reg;
    assign out_stream.base_seq      = out_base_reg;
    assign out_stream.word_position = out_pos_reg;
    assign out_stream.out_word      = out_word_reg;
    assign out_stream.run_last      = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fs_next    = fs_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        ld_kind    = xpf_pkg::KIND_DATA;
        ld_seq     = fs_reg;
        ld_base    = fs_reg;
        ld_pos     = xpf_pkg::POS_W'(idx_reg);
        ld_word    = all_parity_reg[idx_reg];
        ld_last    = 1'b0;
        addr       = idx_reg;
        all_we     = 1'b0;
        even_we    = 1'b0;
        all_wdata  = '0;
        even_wdata = '0;

        case (state_reg)
            xpf_pkg::BK_DATA:
            begin
                addr       = q_data.pos[IDX_W-1:0];
                all_wdata  = all_parity_reg[addr] ^ q_data.word;
                even_wdata = even_parity_reg[addr] ^ q_data.word;
                ld_seq     = q_data.seq;
                ld_base    = q_data.base;
                ld_pos     = q_data.pos;
                ld_word    = q_data.word;
                ld_last    = !q_data.close;
                if (q_valid && out_free)
                begin
                    q_pop   = 1'b1;
                    load    = 1'b1;
                    all_we  = 1'b1;
                    even_we = q_data.even;
                    if (q_data.close)
                    begin
                        state_next = xpf_pkg::BK_ROW;
                        idx_next   = '0;
                        fs_next    = q_data.first_seq;
                    end
                end
            end
            xpf_pkg::BK_ROW:
            begin
                ld_kind = xpf_pkg::KIND_ROW;
                if (out_free)
                begin
                    load   = 1'b1;
                    all_we = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = xpf_pkg::BK_EVEN;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            xpf_pkg::BK_EVEN:
            begin
                ld_kind = xpf_pkg::KIND_EVEN;
                ld_word = even_parity_reg[idx_reg];
                ld_last = (idx_reg == LAST_IDX);
                if (out_free)
                begin
                    load    = 1'b1;
                    even_we = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = xpf_pkg::BK_DATA;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = xpf_pkg::BK_DATA;
            end
        endcase
    end

    // Parity stores: accumulate on data words, clear each entry as it is dumped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS_PER_FRAME; i++)
            begin
                all_parity_reg[i]  <= '0;
                even_parity_reg[i] <= '0;
            end
        end
        else
        begin
            if (all_we)
            begin
                all_parity_reg[addr] <= all_wdata;
            end
            if (even_we)
            begin
                even_parity_reg[addr] <= even_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xpf_pkg::BK_DATA;
            idx_reg       <= '0;
            fs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fs_reg    <= fs_next;
            if (out_free)
            begin
                out_valid_reg <= load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_seq_reg  <= ld_seq;
            out_base_reg <= ld_base;
            out_pos_reg  <= ld_pos;
            out_word_reg <= ld_word;
            out_last_reg <= ld_last;
        end
    end

    `XPF_ASSERT_NOW(a_no_pop_in_dump, state_reg != xpf_pkg::BK_DATA, !q_pop,
        "back: queue popped during parity dump")
    `XPF_ASSERT_NEXT(a_close_starts_dump, q_pop && q_data.close,
        state_reg == xpf_pkg::BK_ROW && idx_reg == '0,
        "back: group close did not start the row parity dump")
    `XPF_ASSERT_NEXT(a_even_ends_dump,
        state_reg == xpf_pkg::BK_EVEN && load && idx_reg == LAST_IDX,
        state_reg == xpf_pkg::BK_DATA && out_valid_reg && out_last_reg,
        "back: last even parity word not flagged as run end")

endmodule

// File: src/xor_parity_fec_encoder.sv
// Top level of the XOR parity FEC encoder
//
//   channel     dir  handshake          payload
//   in_stream   in   valid/ready        frame_seq, payload_word
//   out_stream  out  valid/ready        frame_kind, out_seq, base_seq,
//                                       word_position, out_word, run_last
//   cfg         in   cfg_wr_en          cfg_wr_data -> group_size
//
// Each data word leaves the back end as one result.
// A word that closes a group adds 2*WORDS_PER_FRAME words of parity output, one word a cycle
// from the parity store read port while out_stream is not stalled; queued words wait meanwhile.
// The front end keeps accepting until the two-entry queue is full.
// Reset clears both parity stores and all counters at once; group_size resets to 4.
// A stall on out_stream holds the output register and backs up through the queue.
module xor_parity_fec_encoder #(
    parameter int WORDS_PER_FRAME = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    xpf_in_if.sink                   in_stream,
    xpf_out_if.source                out_stream,
    input  logic                     cfg_wr_en,
    input  logic [xpf_pkg::GS_W-1:0] cfg_wr_data
);

    logic                q_push;
    logic                q_not_full;
    logic                q_pop;
    logic                q_not_empty;
    xpf_pkg::fec_entry_t q_in;
    xpf_pkg::fec_entry_t q_out;

    xpf_front #(
        .WORDS_PER_FRAME (WORDS_PER_FRAME)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_stream   (in_stream),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_ready     (q_not_full),
        .q_push      (q_push),
        .q_entry     (q_in)
    );

    xpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    xpf_back #(
        .WORDS_PER_FRAME (WORDS_PER_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_stream (out_stream)
    );

endmodule

// File: test/fec_stream_checker.sv
// Checker for the XOR parity FEC encoder: predicts every result and compares it
module fec_stream_checker
    import xpf_pkg::*;
#(
    parameter int WPF = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    xpf_in_if               in_mon,
    xpf_out_if              out_mon,
    input  logic            cfg_wr_en,
    input  logic [GS_W-1:0] cfg_wr_data,
    output int              mismatch_count,
    output int              pending_count,
    output int              checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        frame_kind_t       kind;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  base;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              last;
    } fec_result_t;

    fec_result_t queued_outputs[$];

    // Mirror of the encoder state
    logic [WORD_W-1:0] row_acc [WPF];
    logic [WORD_W-1:0] even_acc [WPF];
    logic [SEQ_W-1:0]  cur_seq;
    logic [SEQ_W-1:0]  grp_first_seq;
    logic [GS_W-1:0]   frame_cnt;
    logic [POS_W-1:0]  word_idx;
    logic [GS_W-1:0]   grp_size;

    task automatic push_result(input frame_kind_t kind, input logic [SEQ_W-1:0] seq,
                               input logic [SEQ_W-1:0] base, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] word);
        fec_result_t r;
        r.kind = kind;
        r.seq  = seq;
        r.base = base;
        r.pos  = pos;
        r.word = word;
        r.last = 1'b0;
        queued_outputs.push_back(r);
    endtask

    task automatic encode_word(input logic [SEQ_W-1:0] seq_in, input logic [WORD_W-1:0] w);
        logic [POS_W-1:0] pos;
        int i;
        pos = (word_idx >= WPF) ? '0 : word_idx;
        // sample seq on the first word only
        if (pos == 0)
        begin
            cur_seq = seq_in;
            if (frame_cnt == 0)
                grp_first_seq = cur_seq;
        end
        push_result(KIND_DATA, cur_seq, cur_seq - SEQ_W'(frame_cnt), pos, w);
        row_acc[pos] ^= w;
        if (!frame_cnt[0])
            even_acc[pos] ^= w;
        word_idx = pos + 1'b1;
        if (word_idx >= WPF)
        begin
            word_idx  = '0;
            frame_cnt = frame_cnt + 1'b1;
            // close the group once the count reaches or passes the size
            if (frame_cnt >= grp_size)
            begin
                for (i = 0; i < WPF; i++)
                    push_result(KIND_ROW, grp_first_seq, grp_first_seq, POS_W'(i), row_acc[i]);
                for (i = 0; i < WPF; i++)
                    push_result(KIND_EVEN, grp_first_seq, grp_first_seq, POS_W'(i),
                                even_acc[i]);
                for (i = 0; i < WPF; i++)
                begin
                    row_acc[i]  = '0;
                    even_acc[i] = '0;
                end
                frame_cnt = '0;
            end
        end
        queued_outputs[queued_outputs.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fec_result_t exp_r;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < WPF; i++)
            begin
                row_acc[i]  = '0;
                even_acc[i] = '0;
            end
            cur_seq        = '0;
            grp_first_seq  = '0;
            frame_cnt      = '0;
            word_idx       = '0;
            grp_size       = GROUP_SIZE_RST;
            mismatch_count = 0;
            checked_count  = 0;
            queued_outputs.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                grp_size = cfg_wr_data;
            if (in_mon.valid && in_mon.ready)
                encode_word(in_mon.frame_seq, in_mon.payload_word);
            if (out_mon.valid && out_mon.ready)
            begin
                if (queued_outputs.size() == 0)
                begin
                    $error("result transaction with nothing expected: kind %0d pos %0d",
                           out_mon.frame_kind, out_mon.word_position);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = queued_outputs.pop_front();
                    check_field("frame_kind", WORD_W'(exp_r.kind), WORD_W'(out_mon.frame_kind));
                    check_field("out_seq", WORD_W'(exp_r.seq), WORD_W'(out_mon.out_seq));
                    check_field("base_seq", WORD_W'(exp_r.base), WORD_W'(out_mon.base_seq));
                    check_field("word_position", WORD_W'(exp_r.pos),
                                WORD_W'(out_mon.word_position));
                    check_field("out_word", exp_r.word, out_mon.out_word);
                    check_field("run_last", WORD_W'(exp_r.last), WORD_W'(out_mon.run_last));
                    checked_count++;
                end
            end
            pending_count <= queued_outputs.size();
        end
    end

endmodule

// File: test/xor_parity_fec_encoder_tb.sv
// Testbench top: drives frames and group sizes into the encoder and gives the verdict
module xor_parity_fec_encoder_tb;
    import xpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WPF         = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 64;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [GS_W-1:0] cfg_wr_data;

    int mismatches;
    int pending;
    int checked;

    int send_idle_pct = 35;
    int recv_idle_pct = 76;
    bit hold_off      = 1'b0;
    int frame_pos     = 0;
    int words_sent    = 0;
    int stalled_cycles = 0;

    xpf_in_if  in_stream ();
    xpf_out_if out_stream ();

    xor_parity_fec_encoder #(
        .WORDS_PER_FRAME(WPF)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .out_stream (out_stream),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    fec_stream_checker #(
        .WPF(WPF)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_stream),
        .out_mon       (out_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatch_count(mismatches),
        .pending_count (pending),
        .checked_count (checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_stream.valid && in_stream.ready) || (out_stream.valid && out_stream.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        while (stalled_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random ready, or one long hold-off on request
    initial
    begin
        out_stream.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stream.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                out_stream.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_run(input logic [SEQ_W-1:0] seq, input int count, input bit directed);
        int k;
        logic [WORD_W-1:0] w;
        logic [SEQ_W-1:0]  s;
        for (k = 0; k < count; k++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_stream.valid <= 1'b0;
                @(posedge clk);
            end
            w = {$urandom, $urandom};
            if (directed)
            begin
                case (k)
                    0: w = '1;
                    1: w = '0;
                    2: w = 64'h5555_5555_5555_5555;
                    3: w = 64'hAAAA_AAAA_AAAA_AAAA;
                    4: w = 64'h8000_0000_0000_0000;
                    5: w = 64'h0000_0000_0000_0001;
                    default: ;
                endcase
            end
            // seq on later words must be ignored, so give it junk
            if (frame_pos == 0)
                s = seq;
            else if (directed)
                s = k[0] ? '1 : '0;
            else
                s = $urandom;
            in_stream.valid        <= 1'b1;
            in_stream.frame_seq    <= s;
            in_stream.payload_word <= w;
            do
                @(posedge clk);
            while (!in_stream.ready);
            frame_pos = (frame_pos == WPF - 1) ? 0 : frame_pos + 1;
            words_sent++;
        end
    endtask

    task automatic send_frames(input int n);
        int f;
        for (f = 0; f < n; f++)
            send_run($urandom, WPF, 1'b0);
    endtask

    task automatic wait_idle();
        in_stream.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_group_size(input logic [GS_W-1:0] gs);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gs;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        in_stream.valid        = 1'b0;
        in_stream.frame_seq    = '0;
        in_stream.payload_word = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme words and seq under the reset group size
        send_run(32'hFFFF_FFFF, WPF, 1'b1);
        // Size zero written mid-group: next frame end closes, base wraps below zero
        set_group_size(8'd0);
        send_run(32'h0000_0000, WPF, 1'b0);
        // Write in the middle of a frame, applied at its end
        send_run($urandom, 7, 1'b0);
        set_group_size(8'd255);
        send_run('0, WPF - 7, 1'b0);
        send_frames(1);

        send_idle_pct = 76;
        recv_idle_pct = 35;
        // Lower the size to the frames already in the group, so the next frame passes it
        set_group_size(8'd2);
        send_frames(1);
        set_group_size(8'd3);
        send_frames(3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_group_size(8'd1);
        hold_off = 1'b1;
        send_frames(1);
        set_group_size(8'd2);
        send_frames(2);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d payload words, %0d result transactions checked", words_sent, checked);
        $display("Group sizes 0, 1, 2, 3, 4, 255 with mid-group, mid-frame writes and a long stall");
        if (pending != 0)
            $error("%0d results still expected at the end", pending);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
